/* sv/rv32ie_pkg.sv */
// Package for the RV32I instruction execute block.
// Holds opcodes, status codes and default memory map constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rv32ie_pkg;
	localparam int unsigned DATA_BYTES_DEF = 16384;
	localparam logic [31:0] DATA_BASE_DEF  = 32'h0001_0000;

	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;

	localparam logic [6:0]  F7_ALT      = 7'h20;
	localparam logic [31:0] UPPER_MASK  = 32'hFFFF_F000;
	localparam logic [31:0] ECALL_WORD  = 32'h0000_0073;
	localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
	localparam logic [4:0]  SYSCALL_REG = 5'd17;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ILLEGAL   = 3'd1;
	localparam logic [2:0] ST_LOAD_OOR  = 3'd2;
	localparam logic [2:0] ST_STORE_OOR = 3'd3;
	localparam logic [2:0] ST_ECALL     = 3'd4;
	localparam logic [2:0] ST_EBREAK    = 3'd5;
	localparam logic [2:0] ST_HALT      = 3'd6;
endpackage
`default_nettype wire

/* sv/rv32i_instruction_execute_top.sv */
// RV32I instruction execute block: register file, data RAM and execute logic.
// Depends on rv32ie_pkg.
//
// Each accepted word is one RV32I instruction executed at the kept program
// counter, and each gives one result word. A word's register file read is
// registered into execute and write-back, so words can be accepted every
// cycle while the result output is not held; the data RAM read of a load is
// registered too, and a load holds off the next word while in execute. The
// register file is a two-read-port memory with forwarding of the write made
// in the accept cycle. The data RAM is four byte-lane memories; after reset
// a clearing pass zeroes every row before the first word is accepted.
`timescale 1ns / 1ps
`default_nettype none
module rv32i_instruction_execute_top
	import rv32ie_pkg::*;
#(
	parameter int unsigned DATA_BYTES = DATA_BYTES_DEF,
	parameter logic [31:0] DATA_BASE  = DATA_BASE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        instr_valid,
	output logic             instr_ready,
	input  wire logic [31:0] instr_word,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [31:0]      exec_pc,
	output logic [31:0]      next_pc,
	output logic             reg_written,
	output logic [4:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic [2:0]       status,
	output logic [31:0]      syscall_code
);
	localparam int unsigned ROWS = (DATA_BYTES + 3) / 4;
	localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	logic [31:0] x17_q;
	logic [31:0] rf_a_s1, rf_b_s1;
	logic        vld_a_s1, vld_b_s1, fwd_a_s1, fwd_b_s1;
	logic [31:0] fwd_val_s1;

	logic [7:0]  ram [4][ROWS];
	logic [7:0]  lane_rd_s2 [4];
	logic        clr_busy_q;
	logic [RW-1:0] clr_row_q;

	logic [31:0] pc_q;
	logic        v_s1, v_s2;
	logic [31:0] instr_s1;
	logic [4:0]  rd_s2;
	logic [2:0]  f3_s2;
	logic [1:0]  off0_s2;
	logic [31:0] pc_s2, npc_s2;

	logic        res_valid_q;
	logic [31:0] exec_pc_q, next_pc_q, dest_value_q, syscall_q;
	logic        reg_written_q;
	logic [4:0]  dest_index_q;
	logic [2:0]  status_q;

	logic [6:0]  op, f7;
	logic [4:0]  rd, rs2;
	logic [2:0]  f3;
	logic [31:0] a, b, immi, imms, immb, immj, opb, alu_r, npc, val, addr, off;
	logic        alt, alu_ok, take, wr, is_ld, is_st, in_rng;
	logic [2:0]  st;
	logic [2:0]  size;
	logic [RW-1:0] off_row;
	logic [RW-1:0] lane_row [4];
	logic        lane_en [4];
	logic [7:0]  lane_wd [4];

	logic        out_free, s1_fire, s2_fire, accept;
	logic        wr_en;
	logic [4:0]  wr_idx;
	logic [31:0] wr_val;
	logic [31:0] ld_raw, ld_val;

	assign out_free = !res_valid_q || res_ready;
	assign s1_fire  = v_s1 && (is_ld || out_free);
	assign s2_fire  = v_s2 && out_free;
	assign instr_ready = !clr_busy_q && (!v_s1 || (s1_fire && !is_ld)) && (!v_s2 || s2_fire);
	assign accept   = instr_valid && instr_ready;

	always_comb begin
		op   = instr_s1[6:0];
		rd   = instr_s1[11:7];
		f3   = instr_s1[14:12];
		rs2  = instr_s1[24:20];
		f7   = instr_s1[31:25];
		a    = fwd_a_s1 ? fwd_val_s1 : (vld_a_s1 ? rf_a_s1 : 32'd0);
		b    = fwd_b_s1 ? fwd_val_s1 : (vld_b_s1 ? rf_b_s1 : 32'd0);
		immi = {{20{instr_s1[31]}}, instr_s1[31:20]};
		imms = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
		immb = {{19{instr_s1[31]}}, instr_s1[31], instr_s1[7], instr_s1[30:25],
			instr_s1[11:8], 1'b0};
		immj = {{11{instr_s1[31]}}, instr_s1[31], instr_s1[19:12], instr_s1[20],
			instr_s1[30:21], 1'b0};

		if (op == OP_REG) begin
			opb    = b;
			alt    = (f7 == F7_ALT);
			alu_ok = (f7 == 7'd0 || f7 == F7_ALT) && !(alt && f3 != 3'd0 && f3 != 3'd5);
		end else if (f3 == 3'd1 || f3 == 3'd5) begin
			opb    = {27'd0, rs2};
			alt    = (f7 == F7_ALT);
			alu_ok = (f7 == 7'd0) || (f7 == F7_ALT && f3 == 3'd5);
		end else begin
			opb    = immi;
			alt    = 1'b0;
			alu_ok = 1'b1;
		end
		case (f3)
			3'd0: alu_r = alt ? a - opb : a + opb;
			3'd1: alu_r = a << opb[4:0];
			3'd2: alu_r = {31'd0, $signed(a) < $signed(opb)};
			3'd3: alu_r = {31'd0, a < opb};
			3'd4: alu_r = a ^ opb;
			3'd5: alu_r = alt ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
			3'd6: alu_r = a | opb;
			default: alu_r = a & opb;
		endcase

		case (f3)
			3'd0: take = (a == b);
			3'd1: take = (a != b);
			3'd4: take = $signed(a) < $signed(b);
			3'd5: take = $signed(a) >= $signed(b);
			3'd6: take = a < b;
			default: take = a >= b;
		endcase

		addr = a + ((op == OP_STORE) ? imms : immi);
		off  = addr - DATA_BASE;
		if (op == OP_STORE) begin
			size = 3'd1 << f3[1:0];
		end else begin
			size = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
		end
		in_rng = ({1'b0, off} + {30'd0, size}) <= 33'(DATA_BYTES);

		st    = ST_OK;
		npc   = pc_q + 32'd4;
		val   = 32'd0;
		wr    = 1'b0;
		is_ld = 1'b0;
		is_st = 1'b0;
		if (instr_s1 == 32'd0) begin
			st  = ST_HALT;
			npc = pc_q;
		end else begin
			unique case (op)
				OP_REG, OP_IMM: begin
					if (alu_ok) begin
						val = alu_r;
						wr  = 1'b1;
					end else begin
						st = ST_ILLEGAL;
					end
				end
				OP_LOAD: begin
					if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) st = ST_ILLEGAL;
					else if (!in_rng) st = ST_LOAD_OOR;
					else is_ld = 1'b1;
				end
				OP_STORE: begin
					if (f3 > 3'd2) st = ST_ILLEGAL;
					else if (!in_rng) st = ST_STORE_OOR;
					else is_st = 1'b1;
				end
				OP_BRANCH: begin
					if (f3 == 3'd2 || f3 == 3'd3) st = ST_ILLEGAL;
					else if (take) npc = pc_q + immb;
				end
				OP_JAL: begin
					val = pc_q + 32'd4;
					wr  = 1'b1;
					npc = pc_q + immj;
				end
				OP_JALR: begin
					if (f3 != 3'd0) begin
						st = ST_ILLEGAL;
					end else begin
						val = pc_q + 32'd4;
						wr  = 1'b1;
						npc = (a + immi) & ~32'd1;
					end
				end
				OP_LUI: begin
					val = instr_s1 & UPPER_MASK;
					wr  = 1'b1;
				end
				OP_AUIPC: begin
					val = pc_q + (instr_s1 & UPPER_MASK);
					wr  = 1'b1;
				end
				default: begin
					if (instr_s1 == ECALL_WORD) st = ST_ECALL;
					else if (instr_s1 == EBREAK_WORD) st = ST_EBREAK;
					else st = ST_ILLEGAL;
				end
			endcase
		end
		if (st == ST_ILLEGAL) npc = pc_q;
		if (!(wr && rd != 5'd0)) begin
			wr  = 1'b0;
			val = 32'd0;
		end

		off_row = off[RW+1:2];
		for (int l = 0; l < 4; l++) begin
			logic [1:0] k;
			k = 2'(l) - off[1:0];
			lane_en[l]  = ({1'b0, k} < size);
			lane_row[l] = lane_en[l] ? off_row + RW'(2'(l) < off[1:0]) : off_row;
			lane_wd[l]  = 8'(b >> {k, 3'b000});
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ld_raw[8*k +: 8] = lane_rd_s2[2'(off0_s2 + 2'(k))];
		end
		case (f3_s2)
			3'd0: ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
			3'd1: ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
			3'd4: ld_val = {24'd0, ld_raw[7:0]};
			3'd5: ld_val = {16'd0, ld_raw[15:0]};
			default: ld_val = ld_raw;
		endcase
	end

	always_comb begin
		if (s2_fire) begin
			wr_en  = (rd_s2 != 5'd0);
			wr_idx = rd_s2;
			wr_val = ld_val;
		end else begin
			wr_en  = s1_fire && wr;
			wr_idx = rd;
			wr_val = val;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_mem[wr_idx] <= wr_val;
		end
		if (accept) begin
			rf_a_s1    <= rf_mem[instr_word[19:15]];
			rf_b_s1    <= rf_mem[instr_word[24:20]];
			fwd_val_s1 <= wr_val;
			instr_s1   <= instr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			x17_q    <= '0;
			vld_a_s1 <= 1'b0;
			vld_b_s1 <= 1'b0;
			fwd_a_s1 <= 1'b0;
			fwd_b_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				rf_vld_q[wr_idx] <= 1'b1;
				if (wr_idx == SYSCALL_REG) x17_q <= wr_val;
			end
			if (accept) begin
				vld_a_s1 <= rf_vld_q[instr_word[19:15]];
				vld_b_s1 <= rf_vld_q[instr_word[24:20]];
				fwd_a_s1 <= wr_en && (wr_idx == instr_word[19:15]);
				fwd_b_s1 <= wr_en && (wr_idx == instr_word[24:20]);
			end
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (clr_busy_q) begin
				ram[l][clr_row_q] <= 8'd0;
			end else if (s1_fire && is_st && lane_en[l]) begin
				ram[l][lane_row[l]] <= lane_wd[l];
			end
			if (s1_fire && is_ld) begin
				lane_rd_s2[l] <= ram[l][lane_row[l]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
			pc_q       <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + RW'(1);
				if (clr_row_q == LAST_ROW) clr_busy_q <= 1'b0;
			end
			if (s1_fire) pc_q <= npc;
			if (accept) v_s1 <= 1'b1;
			else if (s1_fire) v_s1 <= 1'b0;
			if (s1_fire && is_ld) v_s2 <= 1'b1;
			else if (s2_fire) v_s2 <= 1'b0;
			if ((s1_fire && !is_ld) || s2_fire) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && is_ld) begin
			rd_s2   <= rd;
			f3_s2   <= f3;
			off0_s2 <= off[1:0];
			pc_s2   <= pc_q;
			npc_s2  <= npc;
		end
		if (s2_fire) begin
			exec_pc_q     <= pc_s2;
			next_pc_q     <= npc_s2;
			reg_written_q <= (rd_s2 != 5'd0);
			dest_index_q  <= rd_s2;
			dest_value_q  <= (rd_s2 != 5'd0) ? ld_val : 32'd0;
			status_q      <= ST_OK;
			syscall_q     <= 32'd0;
		end else if (s1_fire && !is_ld) begin
			exec_pc_q     <= pc_q;
			next_pc_q     <= npc;
			reg_written_q <= wr;
			dest_index_q  <= wr ? rd : 5'd0;
			dest_value_q  <= val;
			status_q      <= st;
			syscall_q     <= (st == ST_ECALL) ? x17_q : 32'd0;
		end
	end

	assign res_valid    = res_valid_q;
	assign exec_pc      = exec_pc_q;
	assign next_pc      = next_pc_q;
	assign reg_written  = reg_written_q;
	assign dest_index   = dest_index_q;
	assign dest_value   = dest_value_q;
	assign status       = status_q;
	assign syscall_code = syscall_q;

	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n) !(v_s1 && v_s2))
		else $error("Execute and load stages are both occupied.");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n) !$rose(clr_busy_q))
		else $error("RAM clearing restarted without reset.");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !instr_ready)
		else $error("Word accepted during RAM clearing.");
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_HALT || status == ST_ILLEGAL) |-> next_pc == exec_pc)
		else $error("Halt or illegal word moved the program counter.");
	a_x0: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && reg_written |-> dest_index != 5'd0 && status == ST_OK)
		else $error("Register write reported for x0 or a failed word.");
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the RV32I instruction execute block.
// Drives instruction words through a valid/ready channel, predicts each result
// word with its own executor model, and compares; depends on rv32ie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import rv32ie_pkg::*;

	localparam int unsigned RAM_BYTES = DATA_BYTES_DEF;
	localparam logic [31:0] RAM_BASE = DATA_BASE_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_WORDS = 1130;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic [2:0]  st;
		logic [31:0] sys;
	} exec_result_t;

	typedef struct {
		logic [31:0]  word;
		bit           typed;
		exec_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic instr_valid = 1'b0;
	logic instr_ready;
	logic [31:0] instr_word = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [31:0] exec_pc, next_pc, dest_value, syscall_code;
	logic reg_written;
	logic [4:0] dest_index;
	logic [2:0] status;

	rv32i_instruction_execute_top DUT (
		.clk(clk), .arst_n(arst_n),
		.instr_valid(instr_valid), .instr_ready(instr_ready), .instr_word(instr_word),
		.res_valid(res_valid), .res_ready(res_ready),
		.exec_pc(exec_pc), .next_pc(next_pc), .reg_written(reg_written),
		.dest_index(dest_index), .dest_value(dest_value), .status(status),
		.syscall_code(syscall_code)
	);

	logic [31:0] model_pc;
	logic [31:0] model_regs [32];
	logic [7:0]  model_ram [RAM_BYTES];
	exec_result_t pending_results [$];
	int errors = 0;
	int send_idle_pct = 12;
	int recv_idle_pct = 57;
	bit recv_hold = 1'b0;
	bit stim_done = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] sx(logic [31:0] v, int bits);
		logic [31:0] m;
		m = 32'd1 << (bits - 1);
		v = v & ((m << 1) - 1);
		return (v ^ m) - m;
	endfunction

	function automatic bit alu_op(logic [2:0] f3, bit alt, logic [31:0] a, logic [31:0] b,
			output logic [31:0] r);
		logic [4:0] sh;
		sh = b[4:0];
		r = '0;
		if (alt && f3 != 3'd0 && f3 != 3'd5) return 1'b0;
		case (f3)
			3'd0: r = alt ? a - b : a + b;
			3'd1: r = a << sh;
			3'd2: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			3'd3: r = (a < b) ? 32'd1 : 32'd0;
			3'd4: r = a ^ b;
			3'd5: r = alt ? 32'($signed(a) >>> sh) : a >> sh;
			3'd6: r = a | b;
			default: r = a & b;
		endcase
		return 1'b1;
	endfunction

	function automatic exec_result_t execute_word(logic [31:0] w);
		exec_result_t r;
		logic [6:0] op, f7;
		logic [4:0] rd, rs1, rs2;
		logic [2:0] f3;
		logic [31:0] a, b, immi, imms, immb, immj, addr, off, val;
		int sz;
		bit wr, take;
		op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20];
		f7 = w[31:25];
		a = model_regs[rs1]; b = model_regs[rs2];
		immi = sx(w >> 20, 12);
		imms = sx({20'd0, w[31:25], w[11:7]}, 12);
		immb = sx({19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
		immj = sx({11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
		r = '0;
		r.pc = model_pc;
		r.npc = model_pc + 4;
		r.st = ST_OK;
		wr = 1'b0;
		val = '0;
		if (w == 32'd0) begin
			r.st = ST_HALT;
			r.npc = model_pc;
		end else if (op == OP_REG) begin
			if ((f7 == 7'd0 || f7 == F7_ALT) && alu_op(f3, f7 == F7_ALT, a, b, val)) wr = 1'b1;
			else r.st = ST_ILLEGAL;
		end else if (op == OP_IMM) begin
			if (f3 == 3'd1 || f3 == 3'd5) begin
				if ((f7 == 7'd0 || (f7 == F7_ALT && f3 == 3'd5))
						&& alu_op(f3, f7 == F7_ALT, a, {27'd0, rs2}, val)) wr = 1'b1;
				else r.st = ST_ILLEGAL;
			end else begin
				void'(alu_op(f3, 1'b0, a, immi, val));
				wr = 1'b1;
			end
		end else if (op == OP_LOAD) begin
			sz = (f3[1:0] == 2'd0) ? 1 : (f3[1:0] == 2'd1) ? 2 : 4;
			addr = a + immi;
			off = addr - RAM_BASE;
			if (f3 == 3'd3 || f3 >= 3'd6) r.st = ST_ILLEGAL;
			else if (64'(off) + sz > RAM_BYTES) r.st = ST_LOAD_OOR;
			else begin
				for (int i = 0; i < sz; i++) val |= 32'(model_ram[off + i]) << (8 * i);
				if (f3 < 3'd2) val = sx(val, 8 * sz);
				wr = 1'b1;
			end
		end else if (op == OP_STORE) begin
			sz = 1 << f3[1:0];
			addr = a + imms;
			off = addr - RAM_BASE;
			if (f3 > 3'd2) r.st = ST_ILLEGAL;
			else if (64'(off) + sz > RAM_BYTES) r.st = ST_STORE_OOR;
			else for (int i = 0; i < sz; i++) model_ram[off + i] = 8'(b >> (8 * i));
		end else if (op == OP_BRANCH) begin
			take = 1'b0;
			case (f3)
				3'd0: take = a == b;
				3'd1: take = a != b;
				3'd4: take = $signed(a) < $signed(b);
				3'd5: take = $signed(a) >= $signed(b);
				3'd6: take = a < b;
				3'd7: take = a >= b;
				default: r.st = ST_ILLEGAL;
			endcase
			if (take) r.npc = model_pc + immb;
		end else if (op == OP_JAL) begin
			val = model_pc + 4;
			wr = 1'b1;
			r.npc = model_pc + immj;
		end else if (op == OP_JALR) begin
			if (f3 != 3'd0) r.st = ST_ILLEGAL;
			else begin
				val = model_pc + 4;
				wr = 1'b1;
				r.npc = (a + immi) & ~32'd1;
			end
		end else if (op == OP_LUI) begin
			val = w & UPPER_MASK;
			wr = 1'b1;
		end else if (op == OP_AUIPC) begin
			val = model_pc + (w & UPPER_MASK);
			wr = 1'b1;
		end else if (w == ECALL_WORD) begin
			r.st = ST_ECALL;
			r.sys = model_regs[SYSCALL_REG];
		end else if (w == EBREAK_WORD) begin
			r.st = ST_EBREAK;
		end else begin
			r.st = ST_ILLEGAL;
		end
		if (r.st == ST_ILLEGAL) begin
			wr = 1'b0;
			r.npc = model_pc;
		end
		if (wr && rd != 5'd0) begin
			model_regs[rd] = val;
			r.wr = 1'b1;
			r.rd = rd;
			r.val = val;
		end
		model_pc = r.npc;
		return r;
	endfunction

	function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
			logic [4:0] rs1, logic [11:0] imm);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
			logic [4:0] rs1, logic [4:0] rs2);
		return {f7, rs2, rs1, f3, rd, OP_REG};
	endfunction

	function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
			logic [11:0] imm);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction

	// Registers x1..x3 are kept pointing into the data RAM most of the time so that
	// loads and stores land in range; other registers carry random values.
	function automatic logic [31:0] random_word();
		int pick;
		logic [4:0] rd, rs1, rs2;
		logic [11:0] imm;
		pick = $urandom_range(0, 99);
		rd = 5'($urandom_range(4, 31));
		rs1 = 5'($urandom_range(0, 31));
		rs2 = 5'($urandom_range(0, 31));
		imm = 12'($urandom);
		if (pick < 8) return enc_i(OP_LUI, 3'($urandom), 5'($urandom_range(1, 3)), 5'd0,
			12'($urandom)) & 32'h0000_0FFF | (RAM_BASE + 32'($urandom_range(0, RAM_BYTES - 1))
			& UPPER_MASK);
		if (pick < 14) return enc_i(OP_IMM, 3'd0, 5'($urandom_range(1, 3)),
			5'($urandom_range(1, 3)), 12'($urandom_range(0, 2047)));
		if (pick < 30) return enc_i(OP_LOAD, 3'($urandom), rd, 5'($urandom_range(1, 3)), imm);
		if (pick < 46) return enc_s(3'($urandom_range(0, 3)), 5'($urandom_range(1, 3)), rs2,
			imm);
		if (pick < 62) return enc_r(($urandom_range(0, 3) == 0) ? F7_ALT :
			($urandom_range(0, 9) == 0 ? 7'($urandom) : 7'd0), 3'($urandom), rd, rs1, rs2);
		if (pick < 76) return {($urandom_range(0, 3) == 0) ? F7_ALT : 7'd0, rs2, rs1,
			3'($urandom), rd, OP_IMM} | (($urandom_range(0, 2) == 0) ? {imm, 20'd0} : 32'd0);
		if (pick < 83) return {$urandom} & 32'hFE00_0F80 | {rs2, rs1, 3'($urandom), 5'd0,
			OP_BRANCH} & 32'h01FF_F07F;
		if (pick < 87) return {20'($urandom), rd, OP_JAL};
		if (pick < 90) return enc_i(OP_JALR, ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'd0,
			rd, rs1, imm);
		if (pick < 93) return {20'($urandom), rd, ($urandom_range(0, 1) == 0) ? OP_LUI :
			OP_AUIPC};
		if (pick < 95) return ($urandom_range(0, 1) == 0) ? ECALL_WORD : EBREAK_WORD;
		if (pick < 96) return 32'd0;
		return $urandom;
	endfunction

	task automatic send_word(logic [31:0] w, bit typed, exec_result_t want);
		exec_result_t got;
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			instr_valid <= 1'b0;
			@(posedge clk);
		end
		instr_valid <= 1'b1;
		instr_word <= w;
		@(posedge clk);
		while (!instr_ready) @(posedge clk);
		got = execute_word(w);
		if (typed && got !== want) begin
			$error("table row 0x%08h: predictor gives %p, table %p", w, got, want);
			errors++;
		end
		pending_results.push_back(got);
	endtask

	initial begin
		stim_row_t rows [$];
		exec_result_t z;
		arst_n <= 1'b0;
		model_pc = '0;
		foreach (model_regs[i]) model_regs[i] = '0;
		foreach (model_ram[i]) model_ram[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		z = '0;
		rows.push_back('{32'd0, 1'b1, '{32'd0, 32'd0, 1'b0, 5'd0, 32'd0, ST_HALT, 32'd0}});
		rows.push_back('{ECALL_WORD, 1'b1, '{32'd0, 32'd4, 1'b0, 5'd0, 32'd0, ST_ECALL, 32'd0}});
		rows.push_back('{EBREAK_WORD, 1'b1, '{32'd4, 32'd8, 1'b0, 5'd0, 32'd0, ST_EBREAK, 0}});
		rows.push_back('{32'hFFFF_FFFF, 1'b1, '{32'd8, 32'd8, 1'b0, 5'd0, 32'd0, ST_ILLEGAL, 0}});
		rows.push_back('{32'hFFFF_F0B7, 1'b1, '{32'd8, 32'd12, 1'b1, 5'd1, 32'hFFFF_F000,
			ST_OK, 0}});
		rows.push_back('{enc_i(OP_LOAD, 3'd2, 5'd5, 5'd0, 12'd0), 1'b1,
			'{32'd12, 32'd16, 1'b0, 5'd0, 32'd0, ST_LOAD_OOR, 0}});
		rows.push_back('{enc_s(3'd2, 5'd0, 5'd1, 12'd0), 1'b1,
			'{32'd16, 32'd20, 1'b0, 5'd0, 32'd0, ST_STORE_OOR, 0}});
		rows.push_back('{{20'h00010, 5'd2, OP_LUI}, 1'b0, z});
		rows.push_back('{enc_s(3'd2, 5'd2, 5'd1, 12'd0), 1'b0, z});
		rows.push_back('{enc_i(OP_LOAD, 3'd0, 5'd6, 5'd2, 12'd1), 1'b0, z});
		rows.push_back('{enc_i(OP_LOAD, 3'd5, 5'd6, 5'd2, 12'd2), 1'b0, z});
		rows.push_back('{enc_i(OP_LOAD, 3'd1, 5'd6, 5'd2, 12'(RAM_BYTES - 2)), 1'b0, z});
		rows.push_back('{enc_i(OP_LOAD, 3'd2, 5'd6, 5'd2, 12'hFFF), 1'b0, z});
		rows.push_back('{enc_r(F7_ALT, 3'd5, 5'd7, 5'd1, 5'd6), 1'b0, z});
		rows.push_back('{enc_r(F7_ALT, 3'd0, 5'd8, 5'd0, 5'd1), 1'b0, z});
		rows.push_back('{enc_r(7'd1, 3'd0, 5'd8, 5'd0, 5'd1), 1'b0, z});
		rows.push_back('{enc_i(OP_IMM, 3'd5, 5'd9, 5'd1, {F7_ALT, 5'd31}), 1'b0, z});
		rows.push_back('{enc_i(OP_IMM, 3'd2, 5'd0, 5'd1, 12'h7FF), 1'b0, z});
		rows.push_back('{{1'b1, 6'h3F, 5'd1, 5'd1, 3'd0, 4'hF, 1'b1, OP_BRANCH}, 1'b0, z});
		rows.push_back('{{1'b0, 6'd0, 5'd1, 5'd0, 3'd2, 4'd2, 1'b0, OP_BRANCH}, 1'b0, z});
		rows.push_back('{{20'hFFFFF, 5'd10, OP_JAL}, 1'b0, z});
		rows.push_back('{enc_i(OP_JALR, 3'd0, 5'd11, 5'd1, 12'h801), 1'b0, z});
		rows.push_back('{{20'hFFFFF, 5'd17, OP_AUIPC}, 1'b0, z});
		rows.push_back('{ECALL_WORD, 1'b0, z});
		foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].want);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 57 : 0;
			for (int n = 0; n < RANDOM_WORDS / 3; n++) send_word(random_word(), 1'b0, z);
		end
		instr_valid <= 1'b0;
		stim_done = 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				exec_result_t want;
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected, exec_pc 0x%08h", exec_pc);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (exec_pc !== want.pc) begin
						$error("exec_pc expected 0x%08h actual 0x%08h", want.pc, exec_pc); errors++;
					end
					if (next_pc !== want.npc) begin
						$error("next_pc expected 0x%08h actual 0x%08h", want.npc, next_pc); errors++;
					end
					if (reg_written !== want.wr) begin
						$error("reg_written expected %0d actual %0d", want.wr, reg_written); errors++;
					end
					if (dest_index !== want.rd) begin
						$error("dest_index expected %0d actual %0d", want.rd, dest_index); errors++;
					end
					if (dest_value !== want.val) begin
						$error("dest_value expected 0x%08h actual 0x%08h", want.val, dest_value);
						errors++;
					end
					if (status !== want.st) begin
						$error("status expected %0d actual %0d", want.st, status); errors++;
					end
					if (syscall_code !== want.sys) begin
						$error("syscall_code expected 0x%08h actual 0x%08h", want.sys, syscall_code);
						errors++;
					end
				end
			end
			res_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// The receiver first idles often, then rarely, then never; one long hold-off
	// at the start of the last phase lets the block fill up and stall its input side.
	initial begin
		@(posedge arst_n);
		wait (send_idle_pct == 57);
		recv_idle_pct = 12;
		wait (send_idle_pct == 0);
		recv_idle_pct = 0;
		recv_hold = 1'b1;
		repeat (300) @(posedge clk);
		recv_hold = 1'b0;
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (!(stim_done && pending_results.size() == 0) && quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((instr_valid && instr_ready) || (res_valid && res_ready)) quiet = 0;
			else quiet++;
		end
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("FAIL");
		end else begin
			repeat (20) @(posedge clk);
			if (errors == 0 && pending_results.size() == 0) begin
				$display("PASS");
			end else begin
				$display("FAIL");
			end
		end
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
sv/rv32ie_pkg.sv
sv/rv32i_instruction_execute_top.sv
tb/testbench.sv
